// ===== hdl/fan_curve_controller_defines.svh =====
// Assertion macros used by the fan curve controller datapath.
`ifndef FAN_CURVE_CONTROLLER_DEFINES_SVH
`define FAN_CURVE_CONTROLLER_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define FCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define FCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fcc_pkg.sv =====
// Package with the shared types, constants and functions of the fan curve controller.
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

  localparam int CURVE_POINTS = 24;
  localparam int PT_IDX_W     = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;
  localparam int PT_CNT_W     = $clog2(CURVE_POINTS + 1);

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;

  localparam int DIV_NUM_W = 15;
  localparam int DIV_DEN_W = 8;

  localparam logic [6:0] DUTY_MAX = 7'd100;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE  = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
  localparam logic [1:0] CFG_FALL_HYST   = 2'd1;
  localparam logic [1:0] CFG_FLOOR       = 2'd2;

  typedef struct packed {
    logic [7:0] temp;
    logic [6:0] cpu;
    logic [6:0] gpu;
  } point_t;

  typedef struct packed {
    logic load_sample;
    logic write_point;
    logic clear_track;
    logic gov_update;
    logic scan_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_direct;
    logic scan_div;
    logic div_done;
    logic change;
    logic out_free;
  } dp_status_t;

  function automatic point_t default_point(input int idx);
    point_t p;
    p = '0;
    case (idx)
      0: p = '{temp: 8'd55, cpu: 7'd25,  gpu: 7'd25};
      1: p = '{temp: 8'd65, cpu: 7'd40,  gpu: 7'd40};
      2: p = '{temp: 8'd75, cpu: 7'd60,  gpu: 7'd60};
      3: p = '{temp: 8'd83, cpu: 7'd80,  gpu: 7'd80};
      4: p = '{temp: 8'd90, cpu: 7'd100, gpu: 7'd100};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/fan_curve_controller.sv =====
// Top level of the fan curve controller.
//
// Input transactions on the s_ group carry one command in s_tuser: write a
// curve point, take a temperature sample, or release tracking. A write or
// a release is done in the cycle it is accepted. A sample goes through the
// cycle it is accepted, an update of the governing temperature, a table
// scan over the curve points in use, a 15-step iterative divide when the
// sample falls between two points, and a finish; s_tready is low while a
// sample is in work. A sample whose duty pair matches the last one sent
// gives no transaction. At the finish a result is loaded into an output
// register on the m_ group; the next input is accepted while it waits. If
// the receiver stalls and a new result is ready, the block holds it until
// m_tready. The cfg group writes point_count (0), fall_hysteresis (1) and
// floor_percent (2) and is always ready. Reset restores the built-in
// five-point curve and register defaults and clears all tracking.
`timescale 1ns / 1ps
`default_nettype none

module fan_curve_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // point_index, point_temp, point_cpu_duty, point_gpu_duty, cpu_millideg,
  // gpu_present, gpu_deg
  input  logic [fcc_pkg::IN_TDATA_W-1:0]   s_tdata,
  // cmd
  input  logic [fcc_pkg::IN_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // cpu_duty, gpu_duty, governing_temp
  output logic [fcc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [7:0]                       cfg_data
);

  fcc_pkg::ctrl_cmd_t  cmd;
  fcc_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  fcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  fcc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_tdata),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/fcc_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fcc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fcc_pkg::DIV_NUM_W-1:0]  dividend,
  input  logic [fcc_pkg::DIV_DEN_W-1:0]  divisor,
  output logic                           done,
  output logic [fcc_pkg::DIV_NUM_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(fcc_pkg::DIV_NUM_W + 1);

  logic                           busy;
  logic [CNT_W-1:0]               cnt;
  logic [fcc_pkg::DIV_DEN_W-1:0]  den;
  logic [fcc_pkg::DIV_DEN_W-1:0]  rem;
  logic [fcc_pkg::DIV_NUM_W-1:0]  quo;
  logic [fcc_pkg::DIV_DEN_W:0]    shifted;
  logic [fcc_pkg::DIV_DEN_W:0]    diff;
  logic                           fits;

  assign shifted  = {rem, quo[fcc_pkg::DIV_NUM_W-1]};
  assign diff     = shifted - {1'b0, den};
  assign fits     = shifted >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(fcc_pkg::DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[fcc_pkg::DIV_DEN_W-1:0];
      end else begin
        rem <= shifted[fcc_pkg::DIV_DEN_W-1:0];
      end
      quo <= {quo[fcc_pkg::DIV_NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fcc_datapath.sv =====
// Datapath: curve table, tracking state, table scan, interpolation and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "fan_curve_controller_defines.svh"

module fcc_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  fcc_pkg::ctrl_cmd_t               cmd,
  output fcc_pkg::dp_status_t              status,
  input  logic [fcc_pkg::IN_TDATA_W-1:0]   in_data,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [7:0]                       cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fcc_pkg::OUT_TDATA_W-1:0]  out_data
);

  // Multiplying by ceil(2^28 / 1000) and dropping 28 bits gives the exact
  // quotient by 1000 for every 18-bit reading.
  localparam logic [18:0] MILLI_RECIP = 19'd268436;
  localparam int          PROD_W      = 37;
  localparam int          PROD_SHIFT  = 28;

  fcc_pkg::point_t table_q [fcc_pkg::CURVE_POINTS];

  logic [4:0] point_count;
  logic [7:0] fall_hyst;
  logic [6:0] floor_pct;

  logic [PROD_W-1:0] prod;
  logic              gpu_present;
  logic [7:0]        gpu_deg;
  logic [7:0]        gov_deg;
  logic              gov_valid;
  logic [6:0]        sent_cpu;
  logic [6:0]        sent_gpu;
  logic              last_valid;

  logic [fcc_pkg::PT_CNT_W-1:0] scan_idx;
  fcc_pkg::point_t              prev;
  logic [6:0]                   res_cpu;
  logic [6:0]                   res_gpu;
  logic [6:0]                   base_cpu;
  logic [6:0]                   base_gpu;
  logic                         neg_cpu;
  logic                         neg_gpu;

  logic [4:0]                   wr_index;
  logic [7:0]                   wr_temp;
  logic [6:0]                   wr_cpu;
  logic [6:0]                   wr_gpu;
  logic [17:0]                  millideg;
  logic [fcc_pkg::PT_CNT_W-1:0] n_eff;
  logic [8:0]                   cdeg;
  logic [7:0]                   cand;
  logic [7:0]                   hot;
  logic                         gov_take;

  fcc_pkg::point_t              entry;
  logic                         at_end;
  logic                         at_first;
  logic                         below;
  logic [7:0]                   dt;
  logic [7:0]                   span;
  logic                         dneg_cpu;
  logic                         dneg_gpu;
  logic [6:0]                   dmag_cpu;
  logic [6:0]                   dmag_gpu;
  logic [fcc_pkg::DIV_NUM_W-1:0] num_cpu;
  logic [fcc_pkg::DIV_NUM_W-1:0] num_gpu;
  logic [6:0]                   dir_cpu;
  logic [6:0]                   dir_gpu;
  logic                         div_start;
  logic                         done_cpu;
  logic                         done_gpu;
  logic [fcc_pkg::DIV_NUM_W-1:0] q_cpu;
  logic [fcc_pkg::DIV_NUM_W-1:0] q_gpu;
  logic [7:0]                   sum_cpu;
  logic [7:0]                   sum_gpu;

  logic [6:0]                   flo;
  logic                         nonzero;
  logic [6:0]                   fin_cpu;
  logic [6:0]                   fin_gpu;
  logic                         change;
  logic                         out_load;

  assign wr_index    = in_data[4:0];
  assign wr_temp     = in_data[12:5];
  assign wr_cpu      = in_data[19:13];
  assign wr_gpu      = in_data[26:20];
  assign millideg    = in_data[44:27];

  always_comb begin
    if (point_count == 5'd0) begin
      n_eff = fcc_pkg::PT_CNT_W'(1);
    end else if (32'(point_count) > fcc_pkg::CURVE_POINTS) begin
      n_eff = fcc_pkg::PT_CNT_W'(fcc_pkg::CURVE_POINTS);
    end else begin
      n_eff = fcc_pkg::PT_CNT_W'(point_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= 5'd5;
      fall_hyst   <= 8'd4;
      floor_pct   <= 7'd20;
    end else if (cfg_write) begin
      case (cfg_index)
        fcc_pkg::CFG_POINT_COUNT: point_count <= cfg_data[4:0];
        fcc_pkg::CFG_FALL_HYST:   fall_hyst   <= cfg_data;
        fcc_pkg::CFG_FLOOR:       floor_pct   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fcc_pkg::CURVE_POINTS; i++) begin
        table_q[i] <= fcc_pkg::default_point(i);
      end
    end else if (cmd.write_point && (32'(wr_index) < fcc_pkg::CURVE_POINTS)) begin
      table_q[fcc_pkg::PT_IDX_W'(wr_index)] <= '{
        temp: wr_temp,
        cpu:  (wr_cpu > fcc_pkg::DUTY_MAX) ? fcc_pkg::DUTY_MAX : wr_cpu,
        gpu:  (wr_gpu > fcc_pkg::DUTY_MAX) ? fcc_pkg::DUTY_MAX : wr_gpu
      };
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      prod        <= PROD_W'(millideg) * PROD_W'(MILLI_RECIP);
      gpu_present <= in_data[45];
      gpu_deg     <= in_data[53:46];
    end
  end

  assign cdeg     = prod[PROD_W-1:PROD_SHIFT];
  assign cand     = (cdeg > 9'd255) ? 8'hFF : cdeg[7:0];
  assign hot      = (gpu_present && (gpu_deg > cand)) ? gpu_deg : cand;
  assign gov_take = !gov_valid || (hot > gov_deg) ||
                    (({1'b0, hot} + {1'b0, fall_hyst}) < {1'b0, gov_deg});

  assign entry    = table_q[fcc_pkg::PT_IDX_W'(scan_idx)];
  assign at_end   = (scan_idx == n_eff);
  assign at_first = (scan_idx == '0);
  assign below    = (gov_deg <= entry.temp);
  assign dt       = gov_deg - prev.temp;
  assign span     = entry.temp - prev.temp;
  assign dneg_cpu = entry.cpu < prev.cpu;
  assign dneg_gpu = entry.gpu < prev.gpu;
  assign dmag_cpu = dneg_cpu ? (prev.cpu - entry.cpu) : (entry.cpu - prev.cpu);
  assign dmag_gpu = dneg_gpu ? (prev.gpu - entry.gpu) : (entry.gpu - prev.gpu);
  assign num_cpu  = fcc_pkg::DIV_NUM_W'(dmag_cpu) * fcc_pkg::DIV_NUM_W'(dt);
  assign num_gpu  = fcc_pkg::DIV_NUM_W'(dmag_gpu) * fcc_pkg::DIV_NUM_W'(dt);

  always_comb begin
    status             = '0;
    status.div_done    = done_cpu && done_gpu;
    status.change      = change;
    status.out_free    = !out_valid || out_ready;
    dir_cpu            = entry.cpu;
    dir_gpu            = entry.gpu;
    if (at_end) begin
      status.scan_direct = 1'b1;
      dir_cpu            = prev.cpu;
      dir_gpu            = prev.gpu;
    end else if (at_first) begin
      if (gov_deg < entry.temp) begin
        status.scan_direct = 1'b1;
        dir_cpu            = 7'd0;
        dir_gpu            = 7'd0;
      end
    end else if (below) begin
      if (entry.temp <= prev.temp) begin
        status.scan_direct = 1'b1;
      end else begin
        status.scan_div = 1'b1;
      end
    end
  end

  assign div_start = cmd.scan_step && status.scan_div;

  fcc_div u_div_cpu (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_cpu),
    .divisor  (span),
    .done     (done_cpu),
    .quotient (q_cpu)
  );

  fcc_div u_div_gpu (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num_gpu),
    .divisor  (span),
    .done     (done_gpu),
    .quotient (q_gpu)
  );

  assign sum_cpu = neg_cpu ? ({1'b0, base_cpu} - q_cpu[7:0]) : ({1'b0, base_cpu} + q_cpu[7:0]);
  assign sum_gpu = neg_gpu ? ({1'b0, base_gpu} - q_gpu[7:0]) : ({1'b0, base_gpu} + q_gpu[7:0]);

  always_ff @(posedge clk) begin
    if (cmd.gov_update) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      if (status.scan_direct) begin
        res_cpu <= dir_cpu;
        res_gpu <= dir_gpu;
      end else if (status.scan_div) begin
        base_cpu <= prev.cpu;
        base_gpu <= prev.gpu;
        neg_cpu  <= dneg_cpu;
        neg_gpu  <= dneg_gpu;
      end else begin
        prev     <= entry;
        scan_idx <= scan_idx + 1'b1;
      end
    end else if (done_cpu) begin
      res_cpu <= sum_cpu[6:0];
      res_gpu <= sum_gpu[6:0];
    end
  end

  assign flo     = (floor_pct > fcc_pkg::DUTY_MAX) ? fcc_pkg::DUTY_MAX : floor_pct;
  assign nonzero = (res_cpu != 7'd0) || (res_gpu != 7'd0);
  assign fin_cpu = (nonzero && (res_cpu < flo)) ? flo : res_cpu;
  assign fin_gpu = (nonzero && (res_gpu < flo)) ? flo : res_gpu;
  assign change  = !last_valid || (fin_cpu != sent_cpu) || (fin_gpu != sent_gpu);
  assign out_load = cmd.finish && change;

  always_ff @(posedge clk) begin
    if (rst) begin
      gov_deg    <= '0;
      gov_valid  <= 1'b0;
      sent_cpu   <= '0;
      sent_gpu   <= '0;
      last_valid <= 1'b0;
    end else if (cmd.clear_track) begin
      gov_valid  <= 1'b0;
      last_valid <= 1'b0;
    end else if (cmd.gov_update) begin
      if (gov_take) begin
        gov_deg   <= hot;
        gov_valid <= 1'b1;
      end
    end else if (out_load) begin
      sent_cpu   <= fin_cpu;
      sent_gpu   <= fin_gpu;
      last_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {2'b00, gov_deg, fin_gpu, fin_cpu};
    end
  end

  `FCC_ASSERT_SAME(a_load_when_free, out_load, (!out_valid || out_ready), "result register overwritten while stalled")
  `FCC_ASSERT_NEXT(a_gov_valid_after_update, cmd.gov_update, gov_valid, "governing temperature not valid after a sample")
  `FCC_ASSERT_SAME(a_scan_in_range, cmd.scan_step, (scan_idx <= n_eff), "table scan ran past the points in use")

endmodule

`default_nettype wire

// ===== hdl/fcc_ctrl.sv =====
// Controller state machine sequencing commands through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module fcc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fcc_pkg::IN_TUSER_W-1:0]  in_cmd,
  input  fcc_pkg::dp_status_t             status,
  output fcc_pkg::ctrl_cmd_t              cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_GOV  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd             = '0;
    cmd.write_point = accept && (in_cmd == fcc_pkg::CMD_WRITE);
    cmd.load_sample = accept && (in_cmd == fcc_pkg::CMD_SAMPLE);
    cmd.clear_track = accept && (in_cmd == fcc_pkg::CMD_RELEASE);
    cmd.gov_update  = (state == ST_GOV);
    cmd.scan_step   = (state == ST_SCAN);
    cmd.finish      = (state == ST_FIN) && (!status.change || status.out_free);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load_sample) begin
          state_next = ST_GOV;
        end
      end
      ST_GOV: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_direct) begin
          state_next = ST_FIN;
        end else if (status.scan_div) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (cmd.finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire
